### hw/rtl/pcfm_pkg.sv
`default_nettype none
package pcfm_pkg;
  localparam int unsigned Frames = 16;
  localparam int unsigned FrameW = $clog2(Frames);
  // Per-frame record: page, valid, dirty, pins, rank
  localparam int unsigned EntryW = 32 + 1 + 1 + 8 + FrameW;

  typedef struct packed {
    logic [31:0]       page;
    logic              valid;
    logic              dirty;
    logic [7:0]        pins;
    logic [FrameW-1:0] rank;
  } entry_t;

  localparam logic [1:0] KindGet   = 2'd0;
  localparam logic [1:0] KindUnpin = 2'd1;
  localparam logic [1:0] KindNew   = 2'd2;
  localparam logic [1:0] KindFlush = 2'd3;

  localparam logic [2:0] StHit       = 3'd0;
  localparam logic [2:0] StMiss      = 3'd1;
  localparam logic [2:0] StNew       = 3'd2;
  localparam logic [2:0] StAllPinned = 3'd3;
  localparam logic [2:0] StUnpinned  = 3'd4;
  localparam logic [2:0] StFlushWr   = 3'd5;
  localparam logic [2:0] StFlushDone = 3'd6;
endpackage
`default_nettype wire

### hw/rtl/pcfm_ram.sv
`default_nettype none
module pcfm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### hw/rtl/page_cache_frame_manager_unit.sv
// Page cache frame manager: frame records live in one RAM, one frame per cycle, but a
// flush scan pauses while a write result waits. A get scans the frames; a miss adds a
// victim scan and a rank pass; a hit that takes the first pin also runs the rank pass.
// One item at a time: a new request is taken only after the last result is accepted.
// Flush: scans every frame, emits one write result per dirty frame, then a done result.
// Reset (rst_ni low, asynchronous) clears control; a sweep then zeroes every record.
`default_nettype none
module page_cache_frame_manager_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] page_id_i,
  input  wire logic [3:0]  frame_i,
  input  wire logic        dirty_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [3:0]       frame_index_o,
  output logic [31:0]      page_number_o,
  output logic             fetch_valid_o,
  output logic             writeback_valid_o,
  output logic [31:0]      writeback_page_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o,
  output logic             last_o
);
  localparam int unsigned FW = pcfm_pkg::FrameW;
  localparam int unsigned CW = FW + 1;
  localparam logic [CW-1:0] FramesC = CW'(pcfm_pkg::Frames);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOOK, S_HITWR, S_VICT, S_RANK, S_UNPIN, S_UNPWR,
    S_FLUSH, S_OUT
  } state_e;

  state_e               state_q;
  logic [CW-1:0]        cnt_q;      // read address issued
  logic                 rv_q;       // read data valid this cycle
  logic [FW-1:0]        ra_q;       // address of rdata
  logic [1:0]           kind_q;
  logic [31:0]          pid_q;
  logic [3:0]           fr_q;
  logic                 dm_q;
  logic [31:0]          hit_q, miss_q;
  // search results
  logic                 found_q;
  logic                 is_hit_q;   // rank pass runs for a first pin on a hit
  logic [FW-1:0]        tgt_q;
  pcfm_pkg::entry_t     tgt_e_q;
  logic                 free_q;
  logic                 back_q;     // return to flush after output
  logic [4:0]           nwr_q;      // flush writes emitted
  logic                 last_pend_q;
  // output register
  logic                 ov_q;
  logic [2:0]           st_q;
  logic [3:0]           ofr_q;
  logic [31:0]          opg_q, owb_q;
  logic                 ofe_q, owbv_q, olast_q;

  logic                 we;
  logic [FW-1:0]        waddr, raddr;
  pcfm_pkg::entry_t     wdata, rd;
  logic [pcfm_pkg::EntryW-1:0] rraw;

  pcfm_ram #(.Width(pcfm_pkg::EntryW), .Depth(pcfm_pkg::Frames)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rraw)
  );
  assign rd = pcfm_pkg::entry_t'(rraw);

  logic scan_done;
  assign scan_done = rv_q && (ra_q == FW'(pcfm_pkg::Frames - 1));

  // Memory port control
  always_comb begin
    we    = 1'b0;
    waddr = ra_q;
    wdata = rd;
    raddr = cnt_q[FW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1; waddr = cnt_q[FW-1:0]; wdata = '0;
      end
      S_HITWR: begin
        we = 1'b1; waddr = tgt_q; wdata = tgt_e_q;
      end
      S_UNPWR: begin
        // release one pin and apply the dirty mark on a cached frame
        we = rd.valid; waddr = tgt_q; wdata = rd;
        if (rd.pins != 8'd0) wdata.pins = rd.pins - 1'b1;
        if (dm_q) wdata.dirty = 1'b1;
      end
      S_RANK: if (rv_q) begin
        we = 1'b1;
        if (ra_q == tgt_q) begin
          wdata.rank  = '0;
          wdata.valid = 1'b1;
          wdata.page  = pid_q;
          wdata.pins  = 8'd1;
          wdata.dirty = is_hit_q ? rd.dirty : (kind_q == pcfm_pkg::KindNew);
        end else if (rd.valid && (free_q || rd.rank < tgt_e_q.rank)) begin
          wdata.rank = rd.rank + 1'b1;
        end
      end
      S_FLUSH: if (rv_q && rd.valid && rd.dirty && nwr_q != 5'd16) begin
        we = 1'b1; wdata.dirty = 1'b0;
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE) && !ov_q;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign frame_index_o = ofr_q;
  assign page_number_o = opg_q;
  assign fetch_valid_o = ofe_q;
  assign writeback_valid_o = owbv_q;
  assign writeback_page_o = owb_q;
  assign hit_total_o = hit_q;
  assign miss_total_o = miss_q;
  assign last_o = olast_q;

  logic flw;
  assign flw = rv_q && rd.valid && rd.dirty && nwr_q != 5'd16;

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; cnt_q <= '0; rv_q <= 1'b0; ov_q <= 1'b0;
      hit_q <= '0; miss_q <= '0; nwr_q <= '0; back_q <= 1'b0;
      ra_q <= '0; found_q <= 1'b0; free_q <= 1'b0; last_pend_q <= 1'b0;
      is_hit_q <= 1'b0; kind_q <= '0; pid_q <= '0; fr_q <= '0; dm_q <= 1'b0;
      tgt_q <= '0; tgt_e_q <= '0; st_q <= '0; ofr_q <= '0; opg_q <= '0;
      owb_q <= '0; ofe_q <= 1'b0; owbv_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      rv_q <= 1'b0;
      ra_q <= cnt_q[FW-1:0];
      unique case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == FramesC - 1'b1) begin
            cnt_q <= '0; state_q <= S_IDLE;
          end
        end
        S_IDLE: if (in_valid_i && in_ready_o) begin
          kind_q <= kind_i; pid_q <= page_id_i; fr_q <= frame_i; dm_q <= dirty_i;
          cnt_q <= '0; found_q <= 1'b0; free_q <= 1'b0; nwr_q <= '0;
          rv_q <= 1'b0; is_hit_q <= 1'b0;
          unique case (kind_i)
            pcfm_pkg::KindGet: begin
              state_q <= S_LOOK; cnt_q <= CW'(1); rv_q <= 1'b1;
            end
            pcfm_pkg::KindNew: begin
              state_q <= S_VICT; cnt_q <= CW'(1); rv_q <= 1'b1;
            end
            pcfm_pkg::KindUnpin: begin
              state_q <= S_UNPIN; tgt_q <= frame_i[FW-1:0];
              cnt_q <= {1'b0, frame_i[FW-1:0]};
            end
            default: begin state_q <= S_FLUSH; cnt_q <= CW'(1); rv_q <= 1'b1; end
          endcase
        end
        S_LOOK: begin
          if (!cnt_q[FW]) begin cnt_q <= cnt_q + 1'b1; rv_q <= 1'b1; end
          if (rv_q && rd.valid && rd.page == pid_q) begin
            // hit at lowest index
            tgt_q <= ra_q;
            tgt_e_q <= rd;
            if (rd.pins != 8'hff) tgt_e_q.pins <= rd.pins + 1'b1;
            if (hit_q != '1) hit_q <= hit_q + 1'b1;
            st_q <= pcfm_pkg::StHit; ofr_q <= 4'(ra_q); opg_q <= pid_q;
            ofe_q <= 1'b0; owbv_q <= 1'b0; owb_q <= '0; olast_q <= 1'b1;
            if (rd.pins == 8'd0) begin
              // becomes most recent: rank pass also sets pins to 1
              cnt_q <= '0; rv_q <= 1'b0; state_q <= S_RANK; found_q <= 1'b1;
              kind_q <= pcfm_pkg::KindGet; is_hit_q <= 1'b1;
            end else begin
              state_q <= S_HITWR;
            end
          end else if (scan_done) begin
            if (miss_q != '1) miss_q <= miss_q + 1'b1;
            cnt_q <= CW'(1); rv_q <= 1'b1; ra_q <= '0; state_q <= S_VICT;
          end
        end
        S_HITWR: begin ov_q <= 1'b1; state_q <= S_OUT; end
        S_VICT: begin
          if (!cnt_q[FW]) begin cnt_q <= cnt_q + 1'b1; rv_q <= 1'b1; end
          if (rv_q && !free_q) begin
            if (!rd.valid) begin
              free_q <= 1'b1; found_q <= 1'b1; tgt_q <= ra_q; tgt_e_q <= rd;
            end else if (rd.pins == 8'd0 && (!found_q || rd.rank > tgt_e_q.rank)) begin
              found_q <= 1'b1; tgt_q <= ra_q; tgt_e_q <= rd;
            end
          end
          if (scan_done) begin
            cnt_q <= '0; state_q <= S_RANK;
          end
        end
        S_RANK: begin
          if (cnt_q == '0 && !rv_q && !found_q) begin
            st_q <= pcfm_pkg::StAllPinned; ofr_q <= '0; opg_q <= pid_q;
            ofe_q <= 1'b0; owbv_q <= 1'b0; owb_q <= '0; olast_q <= 1'b1;
            ov_q <= 1'b1; state_q <= S_OUT;
          end else begin
            if (!cnt_q[FW]) begin cnt_q <= cnt_q + 1'b1; rv_q <= 1'b1; end
            if (scan_done) begin
              if (!is_hit_q) begin
                st_q <= (kind_q == pcfm_pkg::KindGet) ? pcfm_pkg::StMiss
                                                      : pcfm_pkg::StNew;
                ofr_q <= 4'(tgt_q); opg_q <= pid_q;
                ofe_q <= (kind_q == pcfm_pkg::KindGet);
                owbv_q <= tgt_e_q.valid && tgt_e_q.dirty;
                owb_q <= (tgt_e_q.valid && tgt_e_q.dirty) ? tgt_e_q.page : '0;
                olast_q <= 1'b1;
              end
              ov_q <= 1'b1; state_q <= S_OUT;
            end
          end
        end
        S_UNPIN: begin rv_q <= 1'b1; state_q <= S_UNPWR; end
        S_UNPWR: begin
          // rd valid now for tgt_q
          st_q <= pcfm_pkg::StUnpinned; ofr_q <= fr_q; ofe_q <= 1'b0;
          owbv_q <= 1'b0; owb_q <= '0; olast_q <= 1'b1; opg_q <= '0;
          if (32'(fr_q) < pcfm_pkg::Frames && rd.valid) opg_q <= rd.page;
          ov_q <= 1'b1; state_q <= S_OUT;
        end
        S_FLUSH: begin
          if (flw) begin
            st_q <= pcfm_pkg::StFlushWr; ofr_q <= 4'(ra_q); opg_q <= rd.page;
            ofe_q <= 1'b0; owbv_q <= 1'b0; owb_q <= '0; olast_q <= 1'b0;
            ov_q <= 1'b1; nwr_q <= nwr_q + 1'b1;
            back_q <= !scan_done; last_pend_q <= scan_done;
            state_q <= S_OUT;
          end else if (scan_done) begin
            st_q <= pcfm_pkg::StFlushDone; ofr_q <= '0; opg_q <= '0;
            ofe_q <= 1'b0; owbv_q <= 1'b0; owb_q <= '0; olast_q <= 1'b1;
            ov_q <= 1'b1; state_q <= S_OUT;
          end else if (!cnt_q[FW]) begin
            cnt_q <= cnt_q + 1'b1; rv_q <= 1'b1;
          end
        end
        S_OUT: if (ov_q && out_ready_i) begin
          if (back_q) begin
            // re-read the next frame
            back_q <= 1'b0; state_q <= S_FLUSH; rv_q <= 1'b1;
            ra_q <= cnt_q[FW-1:0]; cnt_q <= cnt_q + 1'b1;
          end else if (last_pend_q) begin
            last_pend_q <= 1'b0;
            st_q <= pcfm_pkg::StFlushDone; ofr_q <= '0; opg_q <= '0;
            olast_q <= 1'b1; ov_q <= 1'b1;
          end else begin
            // park the read address on frame zero for the next item
            cnt_q <= '0; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result present right after accept");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_o && !last_pend_q && !back_q |=> state_q == S_IDLE)
    else $error("no return to idle after last result");
  a_flush_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nwr_q <= 5'd16)
    else $error("flush write count overrun");
`endif
endmodule
`default_nettype wire
